// File: rtl/hashed_probe_block_cache_tags_unit_defines.svh
// Assertion macros for the cache tag unit.
// Depends on nothing; included by the top level.
`ifndef HASHED_PROBE_BLOCK_CACHE_TAGS_UNIT_DEFINES_SVH
`define HASHED_PROBE_BLOCK_CACHE_TAGS_UNIT_DEFINES_SVH
// Check a property on every clock edge outside reset.
`define HPB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define HPB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/hpbct_pkg.sv
// Types and constants of the cache tag unit.
// Depends on nothing.
`default_nettype none
package hpbct_pkg;
	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WMARK   = 3'd1;
	localparam logic [2:0] OP_ALLOC   = 3'd2;
	localparam logic [2:0] OP_FLUSH   = 3'd3;
	localparam logic [2:0] OP_FLTXN   = 3'd4;
	localparam logic [2:0] OP_CANCEL  = 3'd5;
	localparam logic [2:0] OP_INVALL  = 3'd6;

	localparam logic [31:0] HASH_MUL  = 32'd391828139;
	localparam logic [31:0] LFSR_MASK = 32'hD000_0001;
	localparam logic [31:0] LFSR_SEED = 32'd1;

	localparam logic REG_SLOTS = 1'b0;
	localparam logic REG_PROBE = 1'b1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] block_number;
		logic [63:0] txn_id;
		logic        frag_mark;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [5:0]  slot_index;
		logic        hit;
		logic        fetch_needed;
		logic        writeback;
		logic [31:0] writeback_block;
		logic        last;
	} res_t;
endpackage
`default_nettype wire

// File: rtl/hashed_probe_block_cache_tags_unit.sv
// Top level of the disk block cache tag unit: slot arrays, probe sequencer, modulo unit.
// Depends on hpbct_pkg and hashed_probe_block_cache_tags_unit_defines.svh.
`default_nettype none
// Tag/policy unit of a hashed block cache. One transaction is taken at a time: in_ready is high
// only while the sequencer is idle. A lookup (read, write-mark, allocate-clear) hashes the block
// number with one 32-bit multiply, reduces it with a bit-serial modulo unit, then walks up to
// probe_length slots (tag memory read, then compare), stopping on a hit, then chooses the victim
// and updates the slot. When no free or non-fragment slot is in the window the LFSR draw goes
// through the same modulo unit twice more. Flush and cancel sweep slots_in_use slots (owner
// memory read, then compare); a flush result that meets a stalled output holds the sweep.
// Invalidate-all and a zero block number go straight to the final result. Results leave
// through a one-entry output register. Config writes on the APB port are registered in the
// access phase, pready is tied high.
module hashed_probe_block_cache_tags_unit #(
	parameter int CACHE_SLOTS = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  hpbct_pkg::req_t      in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output hpbct_pkg::res_t      out_data,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	`include "hashed_probe_block_cache_tags_unit_defines.svh"

	localparam int SW = $clog2(CACHE_SLOTS);
	localparam logic [6:0] NMAX = 7'(CACHE_SLOTS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HMUL = 4'd1;
	localparam logic [3:0] S_HMOD = 4'd2;
	localparam logic [3:0] S_PRD  = 4'd3;
	localparam logic [3:0] S_PCHK = 4'd4;
	localparam logic [3:0] S_VSEL = 4'd5;
	localparam logic [3:0] S_LMOD = 4'd6;
	localparam logic [3:0] S_SMOD = 4'd7;
	localparam logic [3:0] S_VRD  = 4'd8;
	localparam logic [3:0] S_VCHK = 4'd9;
	localparam logic [3:0] S_UPD  = 4'd10;
	localparam logic [3:0] S_SRD  = 4'd11;
	localparam logic [3:0] S_SCHK = 4'd12;
	localparam logic [3:0] S_SEND = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	// config
	logic [6:0] slots_q, probe_q, n_eff, p_eff;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == hpbct_pkg::REG_PROBE) ? {25'd0, probe_q} : {25'd0, slots_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 7'd64;
			probe_q <= 7'd8;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == hpbct_pkg::REG_PROBE) probe_q <= pwdata[6:0];
			else slots_q <= pwdata[6:0];
		end
	end
	assign n_eff = (slots_q == 7'd0) ? 7'd1 : ((slots_q > NMAX) ? NMAX : slots_q);
	assign p_eff = (probe_q == 7'd0) ? 7'd1 : ((probe_q > 7'd64) ? 7'd64 : probe_q);

	// slot state
	logic [CACHE_SLOTS-1:0] valid_q, dirty_q, frag_q;
	logic [31:0] tag_mem [CACHE_SLOTS];
	logic [63:0] own_mem [CACHE_SLOTS];
	logic [31:0] tag_rd_q;
	logic [63:0] own_rd_q;
	logic [SW-1:0] rd_addr;
	logic mem_we;

	// sequencer registers
	logic [3:0] state_q;
	hpbct_pkg::req_t req_q;
	logic [31:0] div_q, lfsr_q, lfsr_nx;
	logic [6:0] rem_q, dvs_q, rem_sh, rem_nx, k_q;
	logic [4:0] cnt_q;
	logic [SW-1:0] start_q, idx_q, s_q, free_q, clean_q;
	logic have_free_q, have_clean_q, hit_q, wb_q;
	logic [31:0] wbblk_q;
	hpbct_pkg::res_t fin_q, pend_q, out_q, scan_res, done_res, pend_fin;
	logic pend_v_q, out_v_q, can_emit, mod_done, scan_hit, scan_end, probe_end;
	logic emit_fin, emit_scan, in_sweep;
	logic [6:0] idx_inc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign can_emit  = !out_v_q || out_ready;
	assign in_sweep  = (state_q == S_SRD) || (state_q == S_SCHK) || (state_q == S_SEND);

	// bit-serial restoring modulo, one dividend bit per cycle
	assign rem_sh   = {rem_q[5:0], div_q[31]};
	assign rem_nx   = (rem_sh >= dvs_q) ? (rem_sh - dvs_q) : rem_sh;
	assign mod_done = (cnt_q == 5'd31);

	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ hpbct_pkg::LFSR_MASK) : (lfsr_q >> 1);
	assign idx_inc = 7'(idx_q) + 7'd1;
	assign probe_end = ((k_q + 7'd1) == p_eff);
	assign scan_end = ((7'(idx_q) + 7'd1) == n_eff);
	assign scan_hit = valid_q[idx_q] && dirty_q[idx_q] &&
		((req_q.opcode == hpbct_pkg::OP_FLUSH) || (own_rd_q == req_q.txn_id));

	always_comb begin
		scan_res = '0;
		scan_res.slot_index = 6'(idx_q);
		scan_res.writeback = 1'b1;
		scan_res.writeback_block = tag_rd_q;
		// final result preset at accept: zeros with last set, error flag for a zero lookup block number
		done_res = '0;
		done_res.status = (in_data.opcode <= hpbct_pkg::OP_ALLOC) &&
			(in_data.block_number == 32'd0);
		done_res.last = 1'b1;
		pend_fin = pend_q;
		pend_fin.last = 1'b1;
	end

	always_comb begin
		unique case (state_q) inside
			S_VRD, S_VCHK, S_UPD: rd_addr = s_q;
			default:              rd_addr = idx_q;
		endcase
	end
	assign mem_we = (state_q == S_UPD) &&
		((req_q.opcode != hpbct_pkg::OP_READ) || !hit_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[s_q] <= req_q.block_number;
			own_mem[s_q] <= req_q.txn_id;
		end
		tag_rd_q <= tag_mem[rd_addr];
		own_rd_q <= own_mem[rd_addr];
	end

	// output register: final result, or a held flush result pushed out by the next hit
	assign emit_fin  = (state_q == S_FIN) && can_emit;
	assign emit_scan = (state_q == S_SCHK) && (req_q.opcode != hpbct_pkg::OP_CANCEL) &&
		scan_hit && pend_v_q && can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (emit_fin || emit_scan) begin
			out_v_q <= 1'b1;
			out_q   <= emit_fin ? fin_q : pend_q;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			dirty_q  <= '0;
			frag_q   <= '0;
			lfsr_q   <= hpbct_pkg::LFSR_SEED;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q) inside
				S_IDLE: if (in_valid) begin
					req_q <= in_data;
					fin_q <= done_res;
					idx_q <= '0;
					pend_v_q <= 1'b0;
					if (in_data.opcode <= hpbct_pkg::OP_ALLOC) begin
						if (in_data.block_number == 32'd0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_HMUL;
						end
					end else if (in_data.opcode == hpbct_pkg::OP_FLUSH ||
							in_data.opcode == hpbct_pkg::OP_FLTXN ||
							in_data.opcode == hpbct_pkg::OP_CANCEL) begin
						state_q <= S_SRD;
					end else begin
						if (in_data.opcode == hpbct_pkg::OP_INVALL) begin
							valid_q <= '0;
							dirty_q <= '0;
							frag_q  <= '0;
						end
						state_q <= S_FIN;
					end
				end
				S_HMUL: begin
					div_q <= 32'(req_q.block_number * hpbct_pkg::HASH_MUL);
					dvs_q <= n_eff;
					rem_q <= '0;
					cnt_q <= '0;
					k_q <= '0;
					have_free_q <= 1'b0;
					have_clean_q <= 1'b0;
					hit_q <= 1'b0;
					wb_q <= 1'b0;
					wbblk_q <= '0;
					state_q <= S_HMOD;
				end
				S_HMOD, S_LMOD, S_SMOD: begin
					cnt_q <= cnt_q + 5'd1;
					if (mod_done) begin
						rem_q <= '0;
						if (state_q == S_HMOD) begin
							start_q <= rem_nx[SW-1:0];
							idx_q <= rem_nx[SW-1:0];
							state_q <= S_PRD;
						end else if (state_q == S_LMOD) begin
							// random victim: (start + draw mod probe) mod slots
							div_q <= 32'(start_q) + 32'(rem_nx);
							dvs_q <= n_eff;
							state_q <= S_SMOD;
						end else begin
							s_q <= rem_nx[SW-1:0];
							state_q <= S_VRD;
						end
					end else begin
						rem_q <= rem_nx;
						div_q <= {div_q[30:0], 1'b0};
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (valid_q[idx_q] && tag_rd_q == req_q.block_number) begin
						hit_q <= 1'b1;
						s_q <= idx_q;
						state_q <= S_UPD;
					end else begin
						if (!valid_q[idx_q] && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q <= idx_q;
						end else if (valid_q[idx_q] && !frag_q[idx_q] && !have_clean_q) begin
							have_clean_q <= 1'b1;
							clean_q <= idx_q;
						end
						k_q <= k_q + 7'd1;
						idx_q <= (idx_inc == n_eff) ? '0 : idx_inc[SW-1:0];
						state_q <= probe_end ? S_VSEL : S_PRD;
					end
				end
				S_VSEL: begin
					if (have_free_q) begin
						s_q <= free_q;
						state_q <= S_UPD;
					end else if (have_clean_q) begin
						s_q <= clean_q;
						state_q <= S_VRD;
					end else begin
						lfsr_q <= lfsr_nx;
						div_q <= lfsr_nx;
						dvs_q <= p_eff;
						cnt_q <= '0;
						state_q <= S_LMOD;
					end
				end
				S_VRD: state_q <= S_VCHK;
				S_VCHK: begin
					if (valid_q[s_q] && dirty_q[s_q]) begin
						wb_q <= 1'b1;
						wbblk_q <= tag_rd_q;
						dirty_q[s_q] <= 1'b0;
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (mem_we) begin
						valid_q[s_q] <= 1'b1;
						dirty_q[s_q] <= (req_q.opcode != hpbct_pkg::OP_READ);
						frag_q[s_q] <= req_q.frag_mark;
					end
					fin_q.slot_index <= 6'(s_q);
					fin_q.hit <= hit_q;
					fin_q.fetch_needed <= (req_q.opcode != hpbct_pkg::OP_ALLOC) && !hit_q;
					fin_q.writeback <= wb_q;
					fin_q.writeback_block <= wbblk_q;
					state_q <= S_FIN;
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (req_q.opcode == hpbct_pkg::OP_CANCEL) begin
						if (scan_hit) begin
							valid_q[idx_q] <= 1'b0;
							dirty_q[idx_q] <= 1'b0;
						end
						idx_q <= idx_q + 1'b1;
						state_q <= scan_end ? S_SEND : S_SRD;
					end else if (!scan_hit || !pend_v_q || can_emit) begin
						// hold one found result back so the last one can be flagged
						if (scan_hit) begin
							pend_q <= scan_res;
							pend_v_q <= 1'b1;
							dirty_q[idx_q] <= 1'b0;
						end
						idx_q <= idx_q + 1'b1;
						state_q <= scan_end ? S_SEND : S_SRD;
					end
				end
				S_SEND: begin
					if (pend_v_q) fin_q <= pend_fin;
					pend_v_q <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: if (can_emit) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HPB_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second transaction taken")
	`HPB_ASSERT(a_wb_not_hit, out_valid && out_data.writeback |-> !out_data.hit, "write-back on hit")
	`HPB_ASSERT(a_pend_in_scan, pend_v_q |-> in_sweep, "held flush result outside a sweep")
	`HPB_ASSERT(a_lfsr_live, lfsr_q != 32'd0, "victim LFSR stuck at zero")
	`HPB_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for the cache tag unit: directed table, then random phases over several configs.
// Depends on hpbct_pkg and hashed_probe_block_cache_tags_unit; self-checking against a predictor.
`timescale 1ns / 1ps
module testbench;
	localparam int NSLOTS = 64;
	localparam int NPHASES = 7;
	localparam int PHASE_ITEMS = 56;

	// Directed row: request plus, where obvious, the single typed result.
	typedef struct {
		hpbct_pkg::req_t rq;
		bit   typed;
		logic st;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	hpbct_pkg::req_t in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	hpbct_pkg::res_t out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the tag arrays, the LFSR and the two registers.
	logic [31:0] tag_sh [NSLOTS];
	logic        valid_sh [NSLOTS];
	logic        dirty_sh [NSLOTS];
	logic        frag_sh [NSLOTS];
	logic [63:0] owner_sh [NSLOTS];
	logic [31:0] lfsr_sh;
	logic [6:0]  slots_reg;
	logic [6:0]  probe_reg;

	hpbct_pkg::res_t expected_results [$];
	int          mismatches = 0;
	bit          use_typed = 0;
	hpbct_pkg::res_t typed_res;

	logic [31:0] block_pool [12];
	logic [63:0] txn_pool [4];

	hashed_probe_block_cache_tags_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// Out-of-range register values saturate.
	function automatic int eff_slots();
		if (slots_reg == 0) return 1;
		if (slots_reg > NSLOTS) return NSLOTS;
		return int'(slots_reg);
	endfunction

	function automatic int eff_probe();
		if (probe_reg == 0) return 1;
		if (probe_reg > 64) return 64;
		return int'(probe_reg);
	endfunction

	// Hashed probe: first hit, else first free slot, else first non-fragment slot,
	// else an LFSR-drawn offset inside the window. Dirty victims are written back.
	task automatic probe_slot(input logic [31:0] blk, output int slot, output logic hit,
			output logic wb, output logic [31:0] wb_blk);
		int n, p, start, idx, free_slot, clean_slot, victim;
		bit have_free, have_clean;
		logic [31:0] hashed;
		logic lsb;
		n = eff_slots();
		p = eff_probe();
		hashed = hpbct_pkg::HASH_MUL * blk;
		start = hashed % n;
		idx = start;
		have_free = 0;
		have_clean = 0;
		free_slot = 0;
		clean_slot = 0;
		hit = 0;
		wb = 0;
		wb_blk = '0;
		for (int k = 0; k < p; k++) begin
			if (!valid_sh[idx]) begin
				if (!have_free) begin
					have_free = 1;
					free_slot = idx;
				end
			end else if (tag_sh[idx] == blk) begin
				hit = 1;
				slot = idx;
				return;
			end else if (!frag_sh[idx] && !have_clean) begin
				have_clean = 1;
				clean_slot = idx;
			end
			idx = (idx + 1 == n) ? 0 : idx + 1;
		end
		if (have_free) begin
			slot = free_slot;
			return;
		end
		if (have_clean) begin
			victim = clean_slot;
		end else begin
			lsb = lfsr_sh[0];
			lfsr_sh = lfsr_sh >> 1;
			if (lsb)
				lfsr_sh = lfsr_sh ^ hpbct_pkg::LFSR_MASK;
			victim = (start + (lfsr_sh % p)) % n;
		end
		if (valid_sh[victim] && dirty_sh[victim]) begin
			wb = 1;
			wb_blk = tag_sh[victim];
			dirty_sh[victim] = 0;
		end
		slot = victim;
	endtask

	// Apply one accepted transaction to the shadow state and queue its results.
	task automatic predict_results(input hpbct_pkg::req_t rq);
		hpbct_pkg::res_t r;
		int slot, n, cnt;
		logic hit, wb;
		logic [31:0] wb_blk;
		r = '0;
		r.last = 1'b1;
		n = eff_slots();
		cnt = 0;
		if (rq.opcode <= hpbct_pkg::OP_ALLOC) begin
			if (rq.block_number == 0) begin
				r.status = 1'b1;
			end else begin
				probe_slot(rq.block_number, slot, hit, wb, wb_blk);
				if (rq.opcode != hpbct_pkg::OP_READ || !hit) begin
					tag_sh[slot] = rq.block_number;
					valid_sh[slot] = 1;
					dirty_sh[slot] = (rq.opcode != hpbct_pkg::OP_READ);
					frag_sh[slot] = rq.frag_mark;
					owner_sh[slot] = rq.txn_id;
				end
				r.slot_index = slot[5:0];
				r.hit = hit;
				r.fetch_needed = (rq.opcode != hpbct_pkg::OP_ALLOC) && !hit;
				r.writeback = wb;
				r.writeback_block = wb_blk;
			end
			expected_results.push_back(r);
		end else if (rq.opcode == hpbct_pkg::OP_FLUSH || rq.opcode == hpbct_pkg::OP_FLTXN) begin
			for (int i = 0; i < n; i++) begin
				if (valid_sh[i] && dirty_sh[i] &&
						(rq.opcode == hpbct_pkg::OP_FLUSH || owner_sh[i] == rq.txn_id)) begin
					r = '0;
					r.slot_index = i[5:0];
					r.writeback = 1'b1;
					r.writeback_block = tag_sh[i];
					dirty_sh[i] = 0;
					expected_results.push_back(r);
					cnt++;
				end
			end
			if (cnt == 0) begin
				r = '0;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				expected_results[$].last = 1'b1;
			end
		end else begin
			if (rq.opcode == hpbct_pkg::OP_CANCEL) begin
				for (int i = 0; i < n; i++)
					if (valid_sh[i] && dirty_sh[i] && owner_sh[i] == rq.txn_id) begin
						valid_sh[i] = 0;
						dirty_sh[i] = 0;
					end
			end else if (rq.opcode == hpbct_pkg::OP_INVALL) begin
				for (int i = 0; i < NSLOTS; i++) begin
					valid_sh[i] = 0;
					dirty_sh[i] = 0;
					frag_sh[i] = 0;
				end
			end
			expected_results.push_back(r);
		end
	endtask

	// Input monitor: every accepted transaction goes through the predictor. Rows with a
	// typed answer replace the predicted one (state still advances).
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_results(in_data);
			if (use_typed) begin
				void'(expected_results.pop_back());
				expected_results.push_back(typed_res);
			end
		end
	end

	// Output checker: field by field against the oldest expectation.
	always @(posedge clk) begin
		hpbct_pkg::res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", out_data);
			end else begin
				e = expected_results.pop_front();
				if (out_data.status !== e.status || out_data.slot_index !== e.slot_index ||
						out_data.hit !== e.hit || out_data.fetch_needed !== e.fetch_needed ||
						out_data.writeback !== e.writeback ||
						out_data.writeback_block !== e.writeback_block ||
						out_data.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: expected %p got %p", e, out_data);
				end
			end
		end
	end

	// Receiver: random stall before each result, runs of zero included.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send(input hpbct_pkg::req_t rq);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write: setup cycle then access cycle; shadow register follows.
	task automatic reg_write(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == hpbct_pkg::REG_SLOTS)
			slots_reg = value[6:0];
		else
			probe_reg = value[6:0];
	endtask

	function automatic dir_row_t row(logic [2:0] op, logic [31:0] blk, logic [63:0] txn,
			logic frag, bit typed, logic st);
		dir_row_t d;
		d.rq.opcode = op;
		d.rq.block_number = blk;
		d.rq.txn_id = txn;
		d.rq.frag_mark = frag;
		d.typed = typed;
		d.st = st;
		return d;
	endfunction

	function automatic hpbct_pkg::req_t random_request();
		hpbct_pkg::req_t rq;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30)      rq.opcode = hpbct_pkg::OP_READ;
		else if (sel < 55) rq.opcode = hpbct_pkg::OP_WMARK;
		else if (sel < 68) rq.opcode = hpbct_pkg::OP_ALLOC;
		else if (sel < 75) rq.opcode = hpbct_pkg::OP_FLUSH;
		else if (sel < 84) rq.opcode = hpbct_pkg::OP_FLTXN;
		else if (sel < 92) rq.opcode = hpbct_pkg::OP_CANCEL;
		else if (sel < 95) rq.opcode = hpbct_pkg::OP_INVALL;
		else if (sel < 97) rq.opcode = 3'd7;
		else               rq.opcode = 3'($urandom_range(0, 2));
		sel = $urandom_range(0, 99);
		if (sel < 80)      rq.block_number = block_pool[$urandom_range(0, 11)];
		else if (sel < 95) rq.block_number = $urandom;
		else               rq.block_number = '0;
		rq.txn_id = ($urandom_range(0, 9) < 8) ? txn_pool[$urandom_range(0, 3)]
			: {$urandom, $urandom};
		rq.frag_mark = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	// Register settings per random phase, extremes first; zero and 127 exercise saturation.
	int phase_slots [NPHASES] = '{64, 0, 127, 5, 64, 3, 40};
	int phase_probe [NPHASES] = '{8, 0, 127, 64, 1, 5, 2};

	initial begin
		dir_row_t dir_rows [$];
		for (int i = 0; i < NSLOTS; i++) begin
			tag_sh[i] = '0;
			valid_sh[i] = 0;
			dirty_sh[i] = 0;
			frag_sh[i] = 0;
			owner_sh[i] = '0;
		end
		lfsr_sh = hpbct_pkg::LFSR_SEED;
		slots_reg = 7'd64;
		probe_reg = 7'd8;

		// Zero-block errors, empty flushes, cancel, undefined opcode, fills, hits,
		// field extremes, a per-transaction flush and cancel, invalidate-all.
		dir_rows.push_back(row(hpbct_pkg::OP_READ,   32'h0, 64'h0, 1'b0, 1, 1'b1));
		dir_rows.push_back(row(hpbct_pkg::OP_WMARK,  32'h0, '1,    1'b1, 1, 1'b1));
		dir_rows.push_back(row(hpbct_pkg::OP_ALLOC,  32'h0, 64'h5, 1'b0, 1, 1'b1));
		dir_rows.push_back(row(hpbct_pkg::OP_FLUSH,  32'h0, 64'h0, 1'b0, 1, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_FLTXN,  32'h0, 64'h1, 1'b0, 1, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_CANCEL, 32'h0, 64'h1, 1'b0, 1, 1'b0));
		dir_rows.push_back(row(3'd7,                 '1,    '1,    1'b1, 1, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_READ,   32'h1, 64'h1, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_READ,   32'h1, 64'h2, 1'b1, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_WMARK,  32'h1, 64'hA, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_WMARK,  '1,    '1,    1'b1, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_ALLOC,  32'h8000_0000, 64'hA, 1'b1, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_ALLOC,  32'h5555_AAAA,
			64'hAAAA_5555_AAAA_5555, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_FLTXN,  32'h0, 64'hA, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_WMARK,  32'h2, 64'hA, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_CANCEL, 32'h0, 64'hA, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_FLUSH,  32'h0, 64'h0, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_READ,   '1,    64'h0, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_INVALL, 32'h0, 64'h0, 1'b0, 1, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_READ,   32'h1, 64'h3, 1'b0, 0, 1'b0));
		dir_rows.push_back(row(hpbct_pkg::OP_FLUSH,  32'h0, 64'h0, 1'b0, 1, 1'b0));

		// Single reset, released on a falling edge.
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			use_typed = dir_rows[i].typed;
			typed_res = '0;
			typed_res.status = dir_rows[i].st;
			typed_res.last = 1'b1;
			send(dir_rows[i].rq);
		end
		use_typed = 0;
		drain();

		for (int ph = 0; ph < NPHASES; ph++) begin
			// Registers change only with the unit idle.
			if (ph > 0) begin
				reg_write(hpbct_pkg::REG_SLOTS, phase_slots[ph]);
				reg_write(hpbct_pkg::REG_PROBE, phase_probe[ph]);
			end
			foreach (block_pool[i])
				do block_pool[i] = $urandom; while (block_pool[i] == 0);
			foreach (txn_pool[i])
				txn_pool[i] = {$urandom, $urandom};
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Hold off mid-phase until every outstanding result is back.
				if (k == PHASE_ITEMS / 2)
					drain();
				send(random_request());
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (expected_results.size() != 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: %0d results never arrived", expected_results.size());
		end
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
